@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define DRAOR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define DRAOR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/draor_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// draor_pkg: shared types and constants of the relay agent option rewriter
// Request, response, configuration and queue entry types, option codes and
// register indexes.
// ---------------------------------------------------------------------------
package draor_pkg;

   localparam int MAX_PAYLOAD_BYTES_DEF = 32;
   localparam int MAX_OPTIONS_LEN_DEF   = 2047;

   localparam int PAYLOAD_STORE_BYTES = 32;
   localparam int PLEN_W              = 8;
   localparam int LEN_W               = 11;
   localparam int QUEUE_DEPTH         = 4;

   localparam logic [7:0]       CODE_PAD         = 8'd0;
   localparam logic [7:0]       CODE_RELAY       = 8'd82;
   localparam logic [7:0]       CODE_END         = 8'd255;
   localparam logic [LEN_W-1:0] SIZE_LIMIT_RESET = 11'd312;
   localparam logic [LEN_W-1:0] LENGTH_SAT       = 11'd2047;
   localparam int               COOKIE_BYTES     = 4;
   localparam int               OPT_HEAD_BYTES   = 2;
   localparam int               OPT_LEN_MAX      = 255;

   localparam logic [1:0] ACT_IGNORE  = 2'd0;
   localparam logic [1:0] ACT_REMOVE  = 2'd1;
   localparam logic [1:0] ACT_ADD     = 2'd2;
   localparam logic [1:0] ACT_REPLACE = 2'd3;

   localparam logic [2:0] CSR_PAYLOAD_LEN   = 3'd0;
   localparam logic [2:0] CSR_PAYLOAD_WORD0 = 3'd1;
   localparam logic [2:0] CSR_PAYLOAD_WORD1 = 3'd2;
   localparam logic [2:0] CSR_PAYLOAD_WORD2 = 3'd3;
   localparam logic [2:0] CSR_PAYLOAD_WORD3 = 3'd4;
   localparam logic [2:0] CSR_SIZE_LIMIT    = 3'd5;

   typedef struct packed {
      logic [7:0] option_byte;
      logic       first;
      logic [1:0] action;
   } req_type;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             out_last;
      logic [LEN_W-1:0] options_length;
      logic             agent_added;
      logic             too_large;
   } rsp_type;

   typedef struct packed {
      logic [5:0]                           payload_len;
      logic [PAYLOAD_STORE_BYTES-1:0][7:0]  payload;
      logic [LEN_W-1:0]                     size_limit;
   } cfg_type;

   // One classified byte handed from the parser to the emitter.
   typedef struct packed {
      logic [7:0]        data;
      logic              is_end;
      logic              insert;
      logic [PLEN_W-1:0] plen;
      logic [LEN_W-1:0]  length;
      logic              too_large;
   } cmd_type;

endpackage

@@ sv/draor_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// draor_front: option parser
// Walks the type-length-value options one byte per request, drops relay
// agent options where the action asks for it and decides on insertion at END.
// ---------------------------------------------------------------------------
module draor_front #(
   parameter int MAX_PAYLOAD_BYTES = draor_pkg::MAX_PAYLOAD_BYTES_DEF,
   parameter int MAX_OPTIONS_LEN   = draor_pkg::MAX_OPTIONS_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  draor_pkg::req_type req_data,
   input  draor_pkg::cfg_type cfg,
   output logic               push_valid,
   input  logic               push_ready,
   output draor_pkg::cmd_type push_data
);
   import draor_pkg::*;

   localparam int OCW = $clog2(MAX_OPTIONS_LEN + 1);
   localparam int SW  = OCW + 2;

   typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_DATA, PH_DONE} phase_type;

   phase_type      phase_ff, phase_in, ph;
   logic [7:0]     bytes_left_ff, bytes_left_in, bl, bl_dec;
   logic           relay_seen_ff, relay_seen_in, rs;
   logic           dropping_ff, dropping_in, dr, dr_new;
   logic [OCW-1:0] out_count_ff, out_count_in, oc, oc_inc;
   logic [1:0]     action_ff, action_in, act;

   logic [7:0]        b;
   logic [PLEN_W-1:0] plen;
   logic [8:0]        opt_len;
   logic [SW-1:0]     total, total_add, size_sum;
   logic              want, big_cond;
   logic              accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.option_byte;

   // A first byte restarts the parser before the byte itself is looked at.
   always_comb begin
      if (req_data.first) begin
         ph  = PH_CODE;
         bl  = '0;
         rs  = 1'b0;
         dr  = 1'b0;
         oc  = '0;
         act = req_data.action;
      end else begin
         ph  = phase_ff;
         bl  = bytes_left_ff;
         rs  = relay_seen_ff;
         dr  = dropping_ff;
         oc  = out_count_ff;
         act = action_ff;
      end
   end

   assign oc_inc = (oc < OCW'(MAX_OPTIONS_LEN)) ? oc + 1'b1 : oc;
   assign bl_dec = (bl != 8'd0) ? bl - 8'd1 : 8'd0;

   assign plen = ({2'b00, cfg.payload_len} > PLEN_W'(MAX_PAYLOAD_BYTES)) ?
                 PLEN_W'(MAX_PAYLOAD_BYTES) : {2'b00, cfg.payload_len};
   assign opt_len   = 9'(OPT_HEAD_BYTES) + {1'b0, plen};
   assign total     = SW'(oc) + SW'(1);
   assign total_add = total + SW'(opt_len);
   assign size_sum  = total_add + SW'(COOKIE_BYTES);
   assign big_cond  = (size_sum >= SW'(cfg.size_limit)) || (opt_len > 9'(OPT_LEN_MAX));
   assign want      = ((act == ACT_ADD) && !rs) || (act == ACT_REPLACE);
   assign dr_new    = (b == CODE_RELAY) && ((act == ACT_REMOVE) || (act == ACT_REPLACE));

   always_comb begin
      logic [SW-1:0] fin;
      fin           = total;
      phase_in      = ph;
      bytes_left_in = bl;
      relay_seen_in = rs;
      dropping_in   = dr;
      out_count_in  = oc;
      action_in     = act;
      push_valid    = 1'b0;
      push_data     = '0;
      push_data.data = b;
      case (ph)
         PH_CODE: begin
            if (b == CODE_END) begin
               push_valid       = 1'b1;
               push_data.is_end = 1'b1;
               push_data.plen   = plen;
               if (want && (plen != '0)) begin
                  if (big_cond) begin
                     push_data.too_large = 1'b1;
                  end else begin
                     push_data.insert = 1'b1;
                     fin              = total_add;
                  end
               end
               push_data.length = (fin > SW'(LENGTH_SAT)) ? LENGTH_SAT : fin[LEN_W-1:0];
               phase_in    = PH_DONE;
               dropping_in = 1'b0;
            end else if (b == CODE_PAD) begin
               push_valid   = 1'b1;
               out_count_in = oc_inc;
            end else begin
               dropping_in   = dr_new;
               relay_seen_in = rs || (b == CODE_RELAY);
               if (!dr_new) begin
                  push_valid   = 1'b1;
                  out_count_in = oc_inc;
               end
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            if (!dr) begin
               push_valid   = 1'b1;
               out_count_in = oc_inc;
            end
            bytes_left_in = b;
            phase_in      = (b == 8'd0) ? PH_CODE : PH_DATA;
         end
         PH_DATA: begin
            if (!dr) begin
               push_valid   = 1'b1;
               out_count_in = oc_inc;
            end
            bytes_left_in = bl_dec;
            if (bl_dec == 8'd0) begin
               phase_in = PH_CODE;
            end
         end
         default: begin
            // After END every byte is dropped until the next packet.
         end
      endcase
      if (!accept) begin
         push_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CODE;
         bytes_left_ff <= '0;
         relay_seen_ff <= 1'b0;
         dropping_ff   <= 1'b0;
         out_count_ff  <= '0;
         action_ff     <= ACT_IGNORE;
      end else if (accept) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         relay_seen_ff <= relay_seen_in;
         dropping_ff   <= dropping_in;
         out_count_ff  <= out_count_in;
         action_ff     <= action_in;
      end
   end

endmodule

@@ sv/draor_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// draor_queue: command queue
// Short first-in first-out buffer between the parser and the emitter.
// ---------------------------------------------------------------------------
module draor_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  draor_pkg::cmd_type push_data,
   output logic               head_valid,
   output draor_pkg::cmd_type head_data,
   input  logic               pop
);
   import draor_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/draor_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// draor_back: response emitter
// Turns queued commands into responses; an END that carries an insertion
// is expanded into the relay agent option followed by END.
// ---------------------------------------------------------------------------
module draor_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  draor_pkg::cmd_type head_data,
   output logic               pop,
   input  draor_pkg::cfg_type cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output draor_pkg::rsp_type rsp_data
);
   import draor_pkg::*;

   localparam int IW = $clog2(PAYLOAD_STORE_BYTES);

   typedef enum logic [1:0] {BK_IDLE, BK_LEN, BK_DATA, BK_END} back_state_type;

   back_state_type    state_ff, state_in;
   logic [PLEN_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              out_free;
   logic [7:0]        payload_byte;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Payload bytes beyond the stored words read as zero.
   assign payload_byte = (idx_ff < PLEN_W'(PAYLOAD_STORE_BYTES)) ?
                         cfg.payload[idx_ff[IW-1:0]] : 8'd0;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      if (out_free && head_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         case (state_ff)
            BK_IDLE: begin
               if (head_data.insert) begin
                  rsp_data_in.out_byte = CODE_RELAY;
                  state_in             = BK_LEN;
               end else begin
                  rsp_data_in.out_byte = head_data.data;
                  if (head_data.is_end) begin
                     rsp_data_in.out_last       = 1'b1;
                     rsp_data_in.options_length = head_data.length;
                     rsp_data_in.too_large      = head_data.too_large;
                  end
                  pop = 1'b1;
               end
            end
            BK_LEN: begin
               rsp_data_in.out_byte = head_data.plen;
               idx_in               = '0;
               state_in             = BK_DATA;
            end
            BK_DATA: begin
               rsp_data_in.out_byte = payload_byte;
               idx_in               = idx_ff + 1'b1;
               if (idx_ff == head_data.plen - 1'b1) begin
                  state_in = BK_END;
               end
            end
            BK_END: begin
               rsp_data_in.out_byte       = CODE_END;
               rsp_data_in.out_last       = 1'b1;
               rsp_data_in.options_length = head_data.length;
               rsp_data_in.agent_added    = 1'b1;
               pop                        = 1'b1;
               state_in                   = BK_IDLE;
            end
            default: begin
               state_in = BK_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ sv/dhcp_relay_agent_option_rewriter_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dhcp_relay_agent_option_rewriter_top: relay agent option rewriter
// Each request is one DHCP options byte after the cookie; first marks the
// opening byte of a packet and carries the action (ignore, remove, add,
// replace). Responses are the rewritten option bytes; the closing END
// response has out_last set and carries the final length and status flags.
// A surviving byte reaches the response channel through the command queue
// and the output register. One request is taken per cycle while the queue
// has room; an END with insertion emits the payload length, capped at
// MAX_PAYLOAD_BYTES, plus 3 responses, one per cycle while not stalled,
// during which the four-entry command queue absorbs further requests
// and then holds req_ready low. A stalled response holds in the output
// register while the parser keeps taking requests until the queue fills.
// Reset empties the queue and the output register, restarts the parser
// and returns the registers to their reset values; there is no clearing
// pass. Registers are written through csr_we/csr_addr/csr_wdata, by the
// user only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module dhcp_relay_agent_option_rewriter_top #(
   parameter int MAX_PAYLOAD_BYTES = draor_pkg::MAX_PAYLOAD_BYTES_DEF,
   parameter int MAX_OPTIONS_LEN   = draor_pkg::MAX_OPTIONS_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  draor_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output draor_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [63:0]        csr_wdata
);
   import draor_pkg::*;

   logic [5:0]       payload_len_ff;
   logic [63:0]      payload_word_ff [4];
   logic [LEN_W-1:0] size_limit_ff;
   cfg_type          cfg;

   logic    push_valid, push_ready, head_valid, pop;
   cmd_type push_data, head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_len_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            payload_word_ff[i] <= '0;
         end
         size_limit_ff <= SIZE_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PAYLOAD_LEN:   payload_len_ff     <= csr_wdata[5:0];
            CSR_PAYLOAD_WORD0: payload_word_ff[0] <= csr_wdata;
            CSR_PAYLOAD_WORD1: payload_word_ff[1] <= csr_wdata;
            CSR_PAYLOAD_WORD2: payload_word_ff[2] <= csr_wdata;
            CSR_PAYLOAD_WORD3: payload_word_ff[3] <= csr_wdata;
            CSR_SIZE_LIMIT:    size_limit_ff      <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.payload_len = payload_len_ff;
   assign cfg.payload     = {payload_word_ff[3], payload_word_ff[2],
                             payload_word_ff[1], payload_word_ff[0]};
   assign cfg.size_limit  = size_limit_ff;

   draor_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
      .MAX_OPTIONS_LEN  (MAX_OPTIONS_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   draor_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .head_valid(head_valid),
      .head_data (head_data),
      .pop       (pop)
   );

   draor_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_data (head_data),
      .pop       (pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/draor_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// draor_checker: port level checks of the rewriter
// Watches the response channel of the top level over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module draor_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input draor_pkg::rsp_type rsp_data
);
   import draor_pkg::*;

   // A stalled response must not move or change.
   `DRAOR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled response changed")

   // Length and flags are carried on the closing response only.
   `DRAOR_ASSERT(a_status_on_last, clock, reset, rsp_valid && !rsp_data.out_last |-> rsp_data.options_length == '0 && !rsp_data.agent_added && !rsp_data.too_large, "status on a non-closing response")

   // The closing response is always the END code with a non-zero length.
   `DRAOR_ASSERT(a_last_is_end, clock, reset, rsp_valid && rsp_data.out_last |-> rsp_data.out_byte == CODE_END && rsp_data.options_length != '0, "closing response is not END")

   // An insertion and a size-limit refusal exclude one another.
   `DRAOR_ASSERT(a_flags_exclusive, clock, reset, rsp_valid |-> !(rsp_data.agent_added && rsp_data.too_large), "inserted and too large together")

   // No response is offered right after reset.
   `DRAOR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind dhcp_relay_agent_option_rewriter_top draor_checker u_draor_checker (.*);
